// ===== design/tsqm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_pkg
// Shared types and constants of the touch sample qualifier and mapper.
// ----------------------------------------------------------------------------
package tsqm_pkg;

    // configuration port
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd7;

    // fixed field widths
    localparam int PANEL_W   = 11;
    localparam int ORIENT_W  = 2;
    localparam int TIME_W    = 32;
    localparam int DIM_EXT_W = 17;

    // register reset values
    localparam int CAL_MAX_RESET  = 4095;
    localparam int PRESS_RESET    = 400;
    localparam logic [ORIENT_W-1:0] ORIENT_RESET  = 2'd1;
    localparam logic [PANEL_W-1:0]  PANEL_W_RESET = 11'd320;
    localparam logic [PANEL_W-1:0]  PANEL_H_RESET = 11'd240;

    // per-axis multiply/divide lane
    typedef enum logic [1:0] {
        LN_IDLE,
        LN_PREP,
        LN_MUL,
        LN_DIV
    } lane_state_t;

    // top-level sequencer
    typedef enum logic {
        TS_IDLE,
        TS_CALC
    } top_state_t;

endpackage : tsqm_pkg
`default_nettype wire

// ===== design/touch_sample_qualifier_mapper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sample_qualifier_mapper_unit
// Touch sample qualification, edge and hold tracking, calibrated screen map.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample that needs the full map goes through
// these steps from one accepted input beat to the next. The beat is taken, and the
// two axis lanes, which run side by side, do a setup step. Then come a shift-add
// multiply by the last screen index and a restoring divide by the calibration
// window, one bit a cycle. A last step moves the result into the output register.
// When both lanes settle in setup, the beat skips the multiply and the divide.
// A lane settles in setup for an empty window, a sample at the window start, an
// offset on the other side of the window start, or an offset at or past the window
// end. The result sits in an output register, so the next sample is taken while a
// finished result still waits for the sink. That next result is not handed over
// until the sink takes the waiting one. Configuration writes take effect at once
// and are meant to happen between samples.
// ----------------------------------------------------------------------------
module touch_sample_qualifier_mapper_unit #(
    parameter int ADC_BITS    = 12,
    parameter int SCREEN_BITS = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [tsqm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [((ADC_BITS > tsqm_pkg::PANEL_W) ? ADC_BITS : tsqm_pkg::PANEL_W)-1:0]
                                                cfg_wdata,
    // sample stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // irq_low, pen_down, sample_x, sample_y, sample_z, now_ms, zero pad
    input  wire logic [((2 + 3*ADC_BITS + tsqm_pkg::TIME_W + 7) / 8) * 8 - 1:0]
                                                s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // point_valid, touch_active, press_edge, release_edge, screen_x, screen_y,
    // hold_ms, zero pad
    output logic      [((4 + 2*SCREEN_BITS + tsqm_pkg::TIME_W + 7) / 8) * 8 - 1:0]
                                                m_tdata
);

    localparam int CFG_W  = (ADC_BITS > tsqm_pkg::PANEL_W) ? ADC_BITS : tsqm_pkg::PANEL_W;
    localparam int OUT_W  = 4 + 2*SCREEN_BITS + tsqm_pkg::TIME_W;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int X_LSB  = 2;
    localparam int Y_LSB  = X_LSB + ADC_BITS;
    localparam int Z_LSB  = Y_LSB + ADC_BITS;
    localparam int T_LSB  = Z_LSB + ADC_BITS;

    tsqm_pkg::top_state_t state_reg, state_next;

    logic [ADC_BITS-1:0]        cal_min_x, cal_max_x, cal_min_y, cal_max_y;
    logic [ADC_BITS-1:0]        pressure_min;
    logic [SCREEN_BITS-1:0]     top_x, top_y;

    logic                       irq_low, pen_down;
    logic [ADC_BITS-1:0]        sample_x, sample_y, sample_z;
    logic [tsqm_pkg::TIME_W-1:0] now_ms;

    logic                       accept;
    logic                       cur;
    logic                       busy_x, busy_y;
    logic [SCREEN_BITS-1:0]     res_x, res_y;
    logic                       load_out;

    logic                       was_touching_reg, was_touching_next;
    logic [tsqm_pkg::TIME_W-1:0] press_start_reg, press_start_next;
    logic                       cur_reg, cur_next;
    logic                       press_reg, press_next;
    logic                       release_reg, release_next;
    logic [tsqm_pkg::TIME_W-1:0] hold_reg, hold_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]           m_data_reg, m_data_next;

    // input beat fields
    assign irq_low  = s_tdata[0];
    assign pen_down = s_tdata[1];
    assign sample_x = s_tdata[X_LSB +: ADC_BITS];
    assign sample_y = s_tdata[Y_LSB +: ADC_BITS];
    assign sample_z = s_tdata[Z_LSB +: ADC_BITS];
    assign now_ms   = s_tdata[T_LSB +: tsqm_pkg::TIME_W];

    tsqm_cfg_regs #(
        .ADC_BITS    (ADC_BITS),
        .SCREEN_BITS (SCREEN_BITS),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cal_min_x    (cal_min_x),
        .cal_max_x    (cal_max_x),
        .cal_min_y    (cal_min_y),
        .cal_max_y    (cal_max_y),
        .pressure_min (pressure_min),
        .top_x        (top_x),
        .top_y        (top_y)
    );

    tsqm_axis_lane #(
        .ADC_BITS    (ADC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .raw    (sample_x),
        .lo     (cal_min_x),
        .hi     (cal_max_x),
        .top    (top_x),
        .busy   (busy_x),
        .result (res_x)
    );

    tsqm_axis_lane #(
        .ADC_BITS    (ADC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .raw    (sample_y),
        .lo     (cal_min_y),
        .hi     (cal_max_y),
        .top    (top_y),
        .busy   (busy_y),
        .result (res_y)
    );

    // qualification of the incoming beat
    assign s_tready = (state_reg == tsqm_pkg::TS_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cur      = irq_low && pen_down && (sample_z >= pressure_min);

    // control and touch state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tsqm_pkg::TS_IDLE;
            was_touching_reg <= 1'b0;
            press_start_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            was_touching_reg <= was_touching_next;
            press_start_reg  <= press_start_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // pending result and output payload
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        press_reg   <= press_next;
        release_reg <= release_next;
        hold_reg    <= hold_next;
        m_data_reg  <= m_data_next;
    end

    // sequencer: take a beat, wait for both lanes, hand over to the output register
    always_comb
    begin
        state_next        = state_reg;
        was_touching_next = was_touching_reg;
        press_start_next  = press_start_reg;
        cur_next          = cur_reg;
        press_next        = press_reg;
        release_next      = release_reg;
        hold_next         = hold_reg;
        load_out          = 1'b0;

        unique case (state_reg)
            tsqm_pkg::TS_IDLE:
            begin
                if (accept)
                begin
                    cur_next          = cur;
                    press_next        = cur && !was_touching_reg;
                    release_next      = !cur && was_touching_reg;
                    was_touching_next = cur;
                    hold_next         = '0;
                    if (cur && !was_touching_reg)
                        press_start_next = now_ms;
                    if (cur && was_touching_reg)
                        hold_next = now_ms - press_start_reg;
                    state_next = tsqm_pkg::TS_CALC;
                end
            end

            tsqm_pkg::TS_CALC:
            begin
                if (!busy_x && !busy_y && (!m_tvalid_reg || m_tready))
                begin
                    load_out   = 1'b1;
                    state_next = tsqm_pkg::TS_IDLE;
                end
            end

            default:
            begin
                state_next = tsqm_pkg::TS_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_data_next   = m_data_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_data_next   = {hold_reg,
                             cur_reg ? res_y : {SCREEN_BITS{1'b0}},
                             cur_reg ? res_x : {SCREEN_BITS{1'b0}},
                             release_reg, press_reg, cur_reg, cur_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(m_data_reg);

endmodule : touch_sample_qualifier_mapper_unit
`default_nettype wire

// ===== design/tsqm_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_cfg_regs
// Configuration register file plus screen extent derivation per rotation.
// ----------------------------------------------------------------------------
module tsqm_cfg_regs #(
    parameter int ADC_BITS    = 12,
    parameter int SCREEN_BITS = 10,
    parameter int CFG_W       = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tsqm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]               cfg_wdata,
    output logic      [ADC_BITS-1:0]            cal_min_x,
    output logic      [ADC_BITS-1:0]            cal_max_x,
    output logic      [ADC_BITS-1:0]            cal_min_y,
    output logic      [ADC_BITS-1:0]            cal_max_y,
    output logic      [ADC_BITS-1:0]            pressure_min,
    output logic      [SCREEN_BITS-1:0]         top_x,
    output logic      [SCREEN_BITS-1:0]         top_y
);

    localparam logic [tsqm_pkg::DIM_EXT_W-1:0] DIM_MAX =
        tsqm_pkg::DIM_EXT_W'(1) << SCREEN_BITS;

    logic [ADC_BITS-1:0]              cal_min_x_reg;
    logic [ADC_BITS-1:0]              cal_max_x_reg;
    logic [ADC_BITS-1:0]              cal_min_y_reg;
    logic [ADC_BITS-1:0]              cal_max_y_reg;
    logic [ADC_BITS-1:0]              pressure_min_reg;
    logic [tsqm_pkg::ORIENT_W-1:0]    orientation_reg;
    logic [tsqm_pkg::PANEL_W-1:0]     panel_width_reg;
    logic [tsqm_pkg::PANEL_W-1:0]     panel_height_reg;
    logic                             even_rot;

    // largest index on an axis: dimension forced into 1 .. 2^SCREEN_BITS, minus one
    function automatic logic [SCREEN_BITS-1:0] fit_top(input logic [tsqm_pkg::PANEL_W-1:0] d);
        logic [tsqm_pkg::DIM_EXT_W-1:0] dw;
        logic [tsqm_pkg::DIM_EXT_W-1:0] dm1;
        dw  = tsqm_pkg::DIM_EXT_W'(d);
        dm1 = dw - tsqm_pkg::DIM_EXT_W'(1);
        if (dw == '0)
            fit_top = '0;
        else if (dw > DIM_MAX)
            fit_top = '1;
        else
            fit_top = dm1[SCREEN_BITS-1:0];
    endfunction

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_min_x_reg    <= '0;
            cal_max_x_reg    <= ADC_BITS'(tsqm_pkg::CAL_MAX_RESET);
            cal_min_y_reg    <= '0;
            cal_max_y_reg    <= ADC_BITS'(tsqm_pkg::CAL_MAX_RESET);
            pressure_min_reg <= ADC_BITS'(tsqm_pkg::PRESS_RESET);
            orientation_reg  <= tsqm_pkg::ORIENT_RESET;
            panel_width_reg  <= tsqm_pkg::PANEL_W_RESET;
            panel_height_reg <= tsqm_pkg::PANEL_H_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tsqm_pkg::REG_CAL_MIN_X:    cal_min_x_reg    <= cfg_wdata[ADC_BITS-1:0];
                tsqm_pkg::REG_CAL_MAX_X:    cal_max_x_reg    <= cfg_wdata[ADC_BITS-1:0];
                tsqm_pkg::REG_CAL_MIN_Y:    cal_min_y_reg    <= cfg_wdata[ADC_BITS-1:0];
                tsqm_pkg::REG_CAL_MAX_Y:    cal_max_y_reg    <= cfg_wdata[ADC_BITS-1:0];
                tsqm_pkg::REG_PRESSURE_MIN: pressure_min_reg <= cfg_wdata[ADC_BITS-1:0];
                tsqm_pkg::REG_ORIENTATION:
                    orientation_reg  <= cfg_wdata[tsqm_pkg::ORIENT_W-1:0];
                tsqm_pkg::REG_PANEL_WIDTH:
                    panel_width_reg  <= cfg_wdata[tsqm_pkg::PANEL_W-1:0];
                tsqm_pkg::REG_PANEL_HEIGHT:
                    panel_height_reg <= cfg_wdata[tsqm_pkg::PANEL_W-1:0];
                default: ;
            endcase
        end
    end

    // even rotations swap the panel extents
    assign even_rot = ~orientation_reg[0];
    assign top_x    = fit_top(even_rot ? panel_height_reg : panel_width_reg);
    assign top_y    = fit_top(even_rot ? panel_width_reg : panel_height_reg);

    assign cal_min_x    = cal_min_x_reg;
    assign cal_max_x    = cal_max_x_reg;
    assign cal_min_y    = cal_min_y_reg;
    assign cal_max_y    = cal_max_y_reg;
    assign pressure_min = pressure_min_reg;

endmodule : tsqm_cfg_regs
`default_nettype wire

// ===== design/tsqm_axis_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_axis_lane
// Bit-serial linear map of one axis: (raw - lo) * top / (hi - lo), clamped.
// ----------------------------------------------------------------------------
module tsqm_axis_lane #(
    parameter int ADC_BITS    = 12,
    parameter int SCREEN_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [ADC_BITS-1:0]    raw,
    input  wire logic [ADC_BITS-1:0]    lo,
    input  wire logic [ADC_BITS-1:0]    hi,
    input  wire logic [SCREEN_BITS-1:0] top,
    output logic                        busy,
    output logic      [SCREEN_BITS-1:0] result
);

    localparam int ACC_W = ADC_BITS + SCREEN_BITS;
    localparam int CNT_W = $clog2(SCREEN_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCREEN_BITS - 1);

    tsqm_pkg::lane_state_t state_reg, state_next;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ADC_BITS-1:0]    mag_r_reg, mag_r_next;
    logic [ADC_BITS-1:0]    mag_d_reg, mag_d_next;
    logic                   neg_r_reg, neg_r_next;
    logic                   neg_d_reg, neg_d_next;
    logic                   zero_r_reg, zero_r_next;
    logic                   zero_d_reg, zero_d_next;
    logic [SCREEN_BITS-1:0] top_reg, top_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;

    logic [ADC_BITS:0]      diff_r;
    logic [ADC_BITS:0]      diff_d;
    logic [ADC_BITS:0]      abs_r;
    logic [ADC_BITS:0]      abs_d;
    logic [ADC_BITS:0]      trial;
    logic [ADC_BITS+1:0]    sub;

    // signed offsets of the sample and the window
    assign diff_r = {1'b0, raw} - {1'b0, lo};
    assign diff_d = {1'b0, hi} - {1'b0, lo};
    assign abs_r  = diff_r[ADC_BITS] ? (~diff_r + 1'b1) : diff_r;
    assign abs_d  = diff_d[ADC_BITS] ? (~diff_d + 1'b1) : diff_d;

    // restoring divide step: remainder in the high bits, quotient shifts in below
    assign trial = {acc_reg[ACC_W-1:SCREEN_BITS], acc_reg[SCREEN_BITS-1]};
    assign sub   = {1'b0, trial} - {2'b00, mag_d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tsqm_pkg::LN_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mag_r_reg  <= mag_r_next;
        mag_d_reg  <= mag_d_next;
        neg_r_reg  <= neg_r_next;
        neg_d_reg  <= neg_d_next;
        zero_r_reg <= zero_r_next;
        zero_d_reg <= zero_d_next;
        top_reg    <= top_next;
        acc_reg    <= acc_next;
    end

    // sequencer: setup, special cases, shift-add multiply, restoring divide
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mag_r_next  = mag_r_reg;
        mag_d_next  = mag_d_reg;
        neg_r_next  = neg_r_reg;
        neg_d_next  = neg_d_reg;
        zero_r_next = zero_r_reg;
        zero_d_next = zero_d_reg;
        top_next    = top_reg;
        acc_next    = acc_reg;

        unique case (state_reg)
            tsqm_pkg::LN_IDLE:
            begin
                if (start)
                begin
                    mag_r_next  = abs_r[ADC_BITS-1:0];
                    mag_d_next  = abs_d[ADC_BITS-1:0];
                    neg_r_next  = diff_r[ADC_BITS];
                    neg_d_next  = diff_d[ADC_BITS];
                    zero_r_next = (diff_r == '0);
                    zero_d_next = (diff_d == '0);
                    top_next    = top;
                    state_next  = tsqm_pkg::LN_PREP;
                end
            end

            tsqm_pkg::LN_PREP:
            begin
                cnt_next = '0;
                if (zero_d_reg || zero_r_reg || (neg_r_reg != neg_d_reg))
                begin
                    // empty window, or quotient at or below zero
                    acc_next   = '0;
                    state_next = tsqm_pkg::LN_IDLE;
                end
                else if (mag_r_reg >= mag_d_reg)
                begin
                    // quotient at or beyond the last index
                    acc_next   = ACC_W'(top_reg);
                    state_next = tsqm_pkg::LN_IDLE;
                end
                else
                begin
                    acc_next   = '0;
                    state_next = tsqm_pkg::LN_MUL;
                end
            end

            tsqm_pkg::LN_MUL:
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                         + (top_reg[SCREEN_BITS-1] ? ACC_W'(mag_r_reg) : '0);
                top_next = {top_reg[SCREEN_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = tsqm_pkg::LN_DIV;
                end
            end

            tsqm_pkg::LN_DIV:
            begin
                if (!sub[ADC_BITS+1])
                    acc_next = {sub[ADC_BITS-1:0], acc_reg[SCREEN_BITS-2:0], 1'b1};
                else
                    acc_next = {trial[ADC_BITS-1:0], acc_reg[SCREEN_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = tsqm_pkg::LN_IDLE;
                end
            end

            default:
            begin
                state_next = tsqm_pkg::LN_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != tsqm_pkg::LN_IDLE);
    assign result = acc_reg[SCREEN_BITS-1:0];

endmodule : tsqm_axis_lane
`default_nettype wire

// ===== design/tsqm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsqm_checker
// Port-level checks of the sample and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module tsqm_checker #(
    parameter int ADC_BITS    = 12,
    parameter int SCREEN_BITS = 10
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((4 + 2*SCREEN_BITS + 32 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int PAY_MSB  = 4 + 2*SCREEN_BITS + 32 - 1;
    localparam int HOLD_LSB = 4 + 2*SCREEN_BITS;

    // a stalled result beat keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // a stalled result beat stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // one sample at a time: ready drops after each accepted beat
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample beat accepted while busy");

    // a non-touch beat carries zero coordinates and hold time
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[PAY_MSB:4] == '0) && !m_tdata[1])
        else $error("non-touch beat with payload");

    // a press starts the hold count at zero and never comes with a release
    a_press_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |->
            (m_tdata[PAY_MSB:HOLD_LSB] == '0) && m_tdata[0] && !m_tdata[3])
        else $error("press beat with nonzero hold time or release edge");

endmodule : tsqm_checker

bind touch_sample_qualifier_mapper_unit tsqm_checker #(
    .ADC_BITS    (ADC_BITS),
    .SCREEN_BITS (SCREEN_BITS)
) u_tsqm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
